// File: rtl/core/uhfr_pkg.sv
// uhfr_pkg: types, constants and register codes shared by the udp header filter
// and rewriter. No dependencies.

package uhfr_pkg;

  localparam int unsigned MAC_W = 48;
  localparam int unsigned IP_W = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned FILL_W = 16;
  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 6;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [7:0] PROTO_UDP = 8'd17;
  localparam logic [15:0] IP_HDR_LEN = 16'd20;
  localparam logic [FILL_W-1:0] FILL_THRESHOLD = 16'd5000;

  localparam logic [1:0] REF_MODE_FWD = 2'd0;
  localparam logic [1:0] REF_MODE_SEP = 2'd1;
  localparam logic [1:0] REF_MODE_EXT = 2'd2;
  localparam logic [1:0] REF_MODE_RSVD = 2'd3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_INPUT_UDP_PORT = 3'd0,
    REG_REF_UDP_PORT = 3'd1,
    REG_INPUT_IP_FILTER = 3'd2,
    REG_REF_IP_FILTER = 3'd3,
    REG_NEW_DST_IP = 3'd4,
    REG_NEW_SRC_IP = 3'd5,
    REG_NEW_DST_MAC = 3'd6,
    REG_REF_MODE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [PORT_W-1:0] input_udp_port;
    logic [PORT_W-1:0] ref_udp_port;
    logic [IP_W-1:0] input_ip_filter;
    logic [IP_W-1:0] ref_ip_filter;
    logic [IP_W-1:0] new_dst_ip;
    logic [IP_W-1:0] new_src_ip;
    logic [MAC_W-1:0] new_dst_mac;
    logic [1:0] ref_mode;
  } cfg_t;

  typedef struct packed {
    logic [15:0] ether_type;
    logic [7:0] ip_protocol;
    logic [IP_W-1:0] ip_dst_addr;
    logic [IP_W-1:0] ip_src_addr;
    logic [PORT_W-1:0] udp_dst_port;
    logic [15:0] ip_total_length;
    logic [MAC_W-1:0] dst_mac_addr;
  } hdr_t;

  typedef struct packed {
    logic forward;
    logic [MAC_W-1:0] dst_mac;
    logic [IP_W-1:0] dst_ip;
    logic [IP_W-1:0] src_ip;
    logic [15:0] psum;
  } res_t;

  // per-word events handed to the counter block
  typedef struct packed {
    logic fwd;
    logic ref_hit;
  } evt_t;

endpackage

// File: rtl/core/uhfr_if.sv
// uhfr_in_if / uhfr_out_if: valid-ready channels for header words and results.
// Depends on uhfr_pkg.

interface uhfr_in_if import uhfr_pkg::*;;
  logic valid;
  logic ready;
  logic [15:0] ether_type;
  logic [7:0] ip_protocol;
  logic [IP_W-1:0] ip_dst_addr;
  logic [IP_W-1:0] ip_src_addr;
  logic [PORT_W-1:0] udp_dst_port;
  logic [15:0] ip_total_length;
  logic [MAC_W-1:0] dst_mac_addr;

  modport source (
    output valid, ether_type, ip_protocol, ip_dst_addr, ip_src_addr,
           udp_dst_port, ip_total_length, dst_mac_addr,
    input ready
  );
  modport sink (
    input valid, ether_type, ip_protocol, ip_dst_addr, ip_src_addr,
          udp_dst_port, ip_total_length, dst_mac_addr,
    output ready
  );
endinterface

interface uhfr_out_if import uhfr_pkg::*;;
  logic valid;
  logic ready;
  logic forward;
  logic [MAC_W-1:0] out_dst_mac;
  logic [IP_W-1:0] out_dst_ip;
  logic [IP_W-1:0] out_src_ip;
  logic [15:0] pseudo_header_sum;
  logic [CNT_W-1:0] ref_packet_count;
  logic fifo_ready;

  modport source (
    output valid, forward, out_dst_mac, out_dst_ip, out_src_ip,
           pseudo_header_sum, ref_packet_count, fifo_ready,
    input ready
  );
  modport sink (
    input valid, forward, out_dst_mac, out_dst_ip, out_src_ip,
          pseudo_header_sum, ref_packet_count, fifo_ready,
    output ready
  );
endinterface

// File: rtl/core/udp_header_filter_rewriter.sv
// udp_header_filter_rewriter: top level of the udp header filter and rewriter.
// Depends on uhfr_pkg, uhfr_if, uhfr_cfg_regs, uhfr_filter and uhfr_counters.

// Takes one parsed header word per clock and returns one result word for each,
// in order. A header word passes an input register, one pass of compare, address
// rewrite and 16-bit pseudo-header sum logic, and lands in the result register,
// from which the result is offered. With the result side ready a word goes in
// and a word comes out every cycle. While a finished result waits in the result
// register the input register can still take one more word; after that the input
// side stalls for as long as the result side holds off. Settings are written over
// the apb port at byte address 8*index with 64-bit data; write them only while no
// word is in flight. The reference counter and the ready flag are updated as each
// word moves into the result register and the result carries their values after
// that word.

module udp_header_filter_rewriter import uhfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  uhfr_in_if.sink               in_ch,
  uhfr_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  hdr_t hdr_in;
  res_t res;
  evt_t evt;
  logic hv;          // input register holds a word
  logic adv;         // word moves from input register to result register
  logic load;        // word accepted on the input channel
  logic [CNT_W-1:0] ref_count;
  logic fifo_ready;

  // result register
  logic ov_r;
  logic ov_nxt;
  res_t res_r;
  logic [CNT_W-1:0] cnt_r;
  logic rdy_r;

  // settings
  uhfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // gather the header fields off the channel
  always_comb begin
    hdr_in.ether_type = in_ch.ether_type;
    hdr_in.ip_protocol = in_ch.ip_protocol;
    hdr_in.ip_dst_addr = in_ch.ip_dst_addr;
    hdr_in.ip_src_addr = in_ch.ip_src_addr;
    hdr_in.udp_dst_port = in_ch.udp_dst_port;
    hdr_in.ip_total_length = in_ch.ip_total_length;
    hdr_in.dst_mac_addr = in_ch.dst_mac_addr;
  end

  // handshake: the result register frees up when empty or being taken,
  // the input register when empty or moving on
  assign adv = hv && (!ov_r || out_ch.ready);
  assign in_ch.ready = !hv || adv;
  assign load = in_ch.valid && in_ch.ready;

  uhfr_filter u_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .adv    (adv),
    .hdr_in (hdr_in),
    .cfg    (cfg),
    .valid  (hv),
    .res    (res),
    .evt    (evt)
  );

  // counters step only when the word really moves on
  uhfr_counters u_cnt (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .evt        (evt),
    .ref_mode   (cfg.ref_mode),
    .ref_count  (ref_count),
    .fifo_ready (fifo_ready)
  );

  assign ov_nxt = adv ? 1'b1 : (out_ch.ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  // payload needs no reset, it is only looked at under valid
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res;
      cnt_r <= ref_count;
      rdy_r <= fifo_ready;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.forward = res_r.forward;
  assign out_ch.out_dst_mac = res_r.dst_mac;
  assign out_ch.out_dst_ip = res_r.dst_ip;
  assign out_ch.out_src_ip = res_r.src_ip;
  assign out_ch.pseudo_header_sum = res_r.psum;
  assign out_ch.ref_packet_count = cnt_r;
  assign out_ch.fifo_ready = rdy_r;

endmodule

// File: rtl/core/uhfr_cfg_regs.sv
// uhfr_cfg_regs: apb register file holding the filter and rewrite settings.
// Depends on uhfr_pkg.

module uhfr_cfg_regs import uhfr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  reg_idx_t idx;
  logic wr_en;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);
  assign wr_en = psel & penable & pwrite & pready;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_INPUT_UDP_PORT:  cfg_nxt.input_udp_port = pwdata[PORT_W-1:0];
        REG_REF_UDP_PORT:    cfg_nxt.ref_udp_port = pwdata[PORT_W-1:0];
        REG_INPUT_IP_FILTER: cfg_nxt.input_ip_filter = pwdata[IP_W-1:0];
        REG_REF_IP_FILTER:   cfg_nxt.ref_ip_filter = pwdata[IP_W-1:0];
        REG_NEW_DST_IP:      cfg_nxt.new_dst_ip = pwdata[IP_W-1:0];
        REG_NEW_SRC_IP:      cfg_nxt.new_src_ip = pwdata[IP_W-1:0];
        REG_NEW_DST_MAC:     cfg_nxt.new_dst_mac = pwdata[MAC_W-1:0];
        REG_REF_MODE:        cfg_nxt.ref_mode = pwdata[1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_INPUT_UDP_PORT:  prdata = APB_DATA_W'(cfg_r.input_udp_port);
      REG_REF_UDP_PORT:    prdata = APB_DATA_W'(cfg_r.ref_udp_port);
      REG_INPUT_IP_FILTER: prdata = APB_DATA_W'(cfg_r.input_ip_filter);
      REG_REF_IP_FILTER:   prdata = APB_DATA_W'(cfg_r.ref_ip_filter);
      REG_NEW_DST_IP:      prdata = APB_DATA_W'(cfg_r.new_dst_ip);
      REG_NEW_SRC_IP:      prdata = APB_DATA_W'(cfg_r.new_src_ip);
      REG_NEW_DST_MAC:     prdata = APB_DATA_W'(cfg_r.new_dst_mac);
      REG_REF_MODE:        prdata = APB_DATA_W'(cfg_r.ref_mode);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/core/uhfr_filter.sv
// uhfr_filter: input register, then match, rewrite and pseudo-header sum.
// Depends on uhfr_pkg.

module uhfr_filter import uhfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  logic adv,
  input  hdr_t hdr_in,
  input  cfg_t cfg,
  output logic valid,
  output res_t res,
  output evt_t evt
);

  logic hv_r;
  logic hv_nxt;
  hdr_t hdr_r;
  logic is_udp;
  logic fwd;
  logic [IP_W-1:0] dip;
  logic [IP_W-1:0] sip;
  logic [15:0] udp_len;
  logic [18:0] sum;
  logic [16:0] fold1;
  logic [16:0] fold2;

  assign hv_nxt = load ? 1'b1 : (adv ? 1'b0 : hv_r);
  assign valid = hv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
    end else begin
      hv_r <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hdr_r <= hdr_in;
    end
  end

  assign is_udp = (hdr_r.ether_type == ETH_IPV4) && (hdr_r.ip_protocol == PROTO_UDP);
  assign fwd = is_udp && (hdr_r.udp_dst_port == cfg.input_udp_port)
            && ((cfg.input_ip_filter == '0) || (hdr_r.ip_dst_addr == cfg.input_ip_filter));

  // rewrites only apply to forwarded words
  assign dip = (fwd && cfg.new_dst_ip != '0) ? cfg.new_dst_ip : hdr_r.ip_dst_addr;
  assign sip = (fwd && cfg.new_src_ip != '0) ? cfg.new_src_ip : hdr_r.ip_src_addr;
  assign udp_len = hdr_r.ip_total_length - IP_HDR_LEN;

  // six 16-bit words, then two end-around folds
  assign sum = 19'(sip[31:16]) + 19'(sip[15:0]) + 19'(dip[31:16]) + 19'(dip[15:0])
             + 19'(hdr_r.ip_protocol) + 19'(udp_len);
  assign fold1 = 17'(sum[18:16]) + 17'(sum[15:0]);
  assign fold2 = 17'(fold1[16]) + 17'(fold1[15:0]);

  always_comb begin
    res.forward = fwd;
    res.dst_mac = (fwd && cfg.new_dst_mac != '0) ? cfg.new_dst_mac : hdr_r.dst_mac_addr;
    res.dst_ip = dip;
    res.src_ip = sip;
    res.psum = fwd ? fold2[15:0] : 16'd0;
  end

  assign evt.fwd = fwd;
  assign evt.ref_hit = is_udp && !fwd && (cfg.ref_mode == REF_MODE_SEP)
                    && (hdr_r.udp_dst_port == cfg.ref_udp_port)
                    && ((cfg.ref_ip_filter == '0) || (hdr_r.ip_dst_addr == cfg.ref_ip_filter));

endmodule

// File: rtl/core/uhfr_counters.sv
// uhfr_counters: reference packet counter, fill counter and sticky ready flag.
// Depends on uhfr_pkg.

module uhfr_counters import uhfr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  evt_t             evt,
  input  logic [1:0]       ref_mode,
  output logic [CNT_W-1:0] ref_count,
  output logic             fifo_ready
);

  logic [CNT_W-1:0] ref_r;
  logic [CNT_W-1:0] ref_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W-1:0] fill_inc;
  logic rdy_r;
  logic rdy_nxt;

  assign fill_inc = fill_r + FILL_W'(1);

  always_comb begin
    ref_nxt = ref_r;
    fill_nxt = fill_r;
    rdy_nxt = rdy_r;
    if (adv) begin
      if ((evt.fwd && ref_mode == REF_MODE_FWD) || evt.ref_hit) begin
        ref_nxt = ref_r + CNT_W'(1);
      end
      if (evt.fwd && !rdy_r) begin
        if (fill_inc > FILL_THRESHOLD) begin
          rdy_nxt = 1'b1;
          fill_nxt = '0;
        end else begin
          fill_nxt = fill_inc;
        end
      end
    end
  end

  // values after this word
  assign ref_count = ref_nxt;
  assign fifo_ready = rdy_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
      fill_r <= '0;
      rdy_r <= 1'b0;
    end else begin
      ref_r <= ref_nxt;
      fill_r <= fill_nxt;
      rdy_r <= rdy_nxt;
    end
  end

endmodule

// File: rtl/core/uhfr_checker.sv
// uhfr_checker: port-level checks on the result channel, bound to the top level.
// Depends on uhfr_pkg and udp_header_filter_rewriter.

module uhfr_checker import uhfr_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             forward,
  input logic [15:0]      pseudo_header_sum,
  input logic [CNT_W-1:0] ref_packet_count,
  input logic             fifo_ready
);

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its count
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(ref_packet_count))
    else $error("result count changed while stalled");

  // dropped words carry no checksum seed
  a_drop_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !forward |-> pseudo_header_sum == 16'd0)
    else $error("dropped word with nonzero pseudo header sum");

  // the ready flag never falls once shown
  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && fifo_ready |=> !out_valid || fifo_ready)
    else $error("fifo ready flag fell");

endmodule

bind udp_header_filter_rewriter uhfr_checker u_uhfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .forward           (out_ch.forward),
  .pseudo_header_sum (out_ch.pseudo_header_sum),
  .ref_packet_count  (out_ch.ref_packet_count),
  .fifo_ready        (out_ch.fifo_ready)
);

// File: sim/tb_udp_header_filter_rewriter.sv
// tb_udp_header_filter_rewriter: self-checking testbench for the udp header filter and rewriter
// needs uhfr_pkg, uhfr_in_if / uhfr_out_if and the udp_header_filter_rewriter top level

module tb_udp_header_filter_rewriter;
  import uhfr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // codes used to build broken headers
  localparam logic [15:0] ETH_IPV4_SWAPPED = 16'h0008;  // ipv4 type with bytes swapped
  localparam logic [7:0]  PROTO_TCP        = 8'd6;

  typedef enum {HDR_FWD, HDR_REF, HDR_NEAR, HDR_NOISE} hdr_kind_t;

  // one expected result word: the rewritten header plus the counter outputs
  typedef struct packed {
    res_t             word;
    logic [CNT_W-1:0] ref_count;
    logic             ready;
  } outcome_t;

  logic clk;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  uhfr_in_if  in_ch ();
  uhfr_out_if out_ch ();

  udp_header_filter_rewriter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the settings and of the counter state, all zero out of reset
  cfg_t             cfg        = '0;
  logic [CNT_W-1:0] ref_tally  = '0;
  logic [FILL_W-1:0] fill_tally = '0;
  logic             fifo_armed = 1'b0;

  hdr_t     pending[$];    // headers waiting to be driven
  outcome_t forecast[$];   // expected result words, oldest first
  hdr_t     next_hdr;
  hdr_t     seen_hdr;
  outcome_t want;

  int   fail_count = 0;
  int   src_gap    = 0;
  int   sink_gap   = 0;
  logic in_taken   = 1'b0;
  logic calm       = 1'b0;   // no idling on either side
  logic hold_go    = 1'b0;
  logic long_hold  = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: forwarding decision, rewrites, pseudo-header sum and counters
  // ---------------------------------------------------------------------------
  function automatic outcome_t filter_and_rewrite(input hdr_t h);
    outcome_t    o;
    logic        is_udp;
    logic        fwd;
    logic [15:0] udp_len;
    int unsigned sum;
    is_udp = (h.ether_type == ETH_IPV4) && (h.ip_protocol == PROTO_UDP);
    fwd = is_udp && (h.udp_dst_port == cfg.input_udp_port) &&
          (cfg.input_ip_filter == '0 || h.ip_dst_addr == cfg.input_ip_filter);
    o = '0;
    o.word.forward = fwd;
    o.word.dst_mac = h.dst_mac_addr;
    o.word.dst_ip  = h.ip_dst_addr;
    o.word.src_ip  = h.ip_src_addr;
    if (fwd) begin
      // a zero register leaves the original field in place
      if (cfg.new_dst_mac != '0) o.word.dst_mac = cfg.new_dst_mac;
      if (cfg.new_dst_ip != '0) o.word.dst_ip = cfg.new_dst_ip;
      if (cfg.new_src_ip != '0) o.word.src_ip = cfg.new_src_ip;
      // udp length wraps when the total length is below the ip header size
      udp_len = h.ip_total_length - IP_HDR_LEN;
      sum = 32'(o.word.src_ip[31:16]) + 32'(o.word.src_ip[15:0]) +
            32'(o.word.dst_ip[31:16]) + 32'(o.word.dst_ip[15:0]) +
            32'(h.ip_protocol) + 32'(udp_len);
      sum = (sum >> 16) + (sum & 32'hFFFF);
      sum = (sum >> 16) + (sum & 32'hFFFF);
      o.word.psum = sum[15:0];
      if (cfg.ref_mode == REF_MODE_FWD) ref_tally = ref_tally + CNT_W'(1);
      // fill count runs only until the flag is raised, the flag then sticks
      if (!fifo_armed) begin
        fill_tally = fill_tally + FILL_W'(1);
        if (fill_tally > FILL_THRESHOLD) begin
          fifo_armed = 1'b1;
          fill_tally = '0;
        end
      end
    end else if (is_udp && cfg.ref_mode == REF_MODE_SEP &&
                 h.udp_dst_port == cfg.ref_udp_port &&
                 (cfg.ref_ip_filter == '0 || h.ip_dst_addr == cfg.ref_ip_filter)) begin
      ref_tally = ref_tally + CNT_W'(1);
    end
    o.ref_count = ref_tally;
    o.ready     = fifo_armed;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: checks result words first, then records accepted header words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (forecast.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        want = forecast.pop_front();
        check_field("forward", 64'(want.word.forward), 64'(out_ch.forward));
        check_field("out_dst_mac", 64'(want.word.dst_mac), 64'(out_ch.out_dst_mac));
        check_field("out_dst_ip", 64'(want.word.dst_ip), 64'(out_ch.out_dst_ip));
        check_field("out_src_ip", 64'(want.word.src_ip), 64'(out_ch.out_src_ip));
        check_field("pseudo_header_sum", 64'(want.word.psum),
                    64'(out_ch.pseudo_header_sum));
        check_field("ref_packet_count", 64'(want.ref_count),
                    64'(out_ch.ref_packet_count));
        check_field("fifo_ready", 64'(want.ready), 64'(out_ch.fifo_ready));
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen_hdr.ether_type      = in_ch.ether_type;
      seen_hdr.ip_protocol     = in_ch.ip_protocol;
      seen_hdr.ip_dst_addr     = in_ch.ip_dst_addr;
      seen_hdr.ip_src_addr     = in_ch.ip_src_addr;
      seen_hdr.udp_dst_port    = in_ch.udp_dst_port;
      seen_hdr.ip_total_length = in_ch.ip_total_length;
      seen_hdr.dst_mac_addr    = in_ch.dst_mac_addr;
      forecast.push_back(filter_and_rewrite(seen_hdr));
    end
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
  end

  // ---------------------------------------------------------------------------
  // driver: offers queued headers on the falling edge, with random idle bursts
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (src_gap != 0) begin
        src_gap     <= src_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (!calm && pending.size() != 0 && $urandom_range(0, 7) == 0) begin
        src_gap     <= $urandom_range(0, 2);
        in_ch.valid <= 1'b0;
      end else if (pending.size() != 0) begin
        next_hdr = pending.pop_front();
        in_ch.ether_type      <= next_hdr.ether_type;
        in_ch.ip_protocol     <= next_hdr.ip_protocol;
        in_ch.ip_dst_addr     <= next_hdr.ip_dst_addr;
        in_ch.ip_src_addr     <= next_hdr.ip_src_addr;
        in_ch.udp_dst_port    <= next_hdr.udp_dst_port;
        in_ch.ip_total_length <= next_hdr.ip_total_length;
        in_ch.dst_mac_addr    <= next_hdr.dst_mac_addr;
        in_ch.valid           <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side: random stall bursts, plus the long hold-off when requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (long_hold) begin
      out_ch.ready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap     <= sink_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      sink_gap     <= $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // long hold-off so the pipeline fills up and back-pressures the input
  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (60) @(posedge clk);
    long_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // settings port
  // ---------------------------------------------------------------------------
  task automatic apb_access(input logic wr, input reg_idx_t idx,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write one register, mirror it in the shadow and read it back
  task automatic write_setting(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] rdata;
    case (idx)
      REG_INPUT_UDP_PORT:  cfg.input_udp_port  = value[PORT_W-1:0];
      REG_REF_UDP_PORT:    cfg.ref_udp_port    = value[PORT_W-1:0];
      REG_INPUT_IP_FILTER: cfg.input_ip_filter = value[IP_W-1:0];
      REG_REF_IP_FILTER:   cfg.ref_ip_filter   = value[IP_W-1:0];
      REG_NEW_DST_IP:      cfg.new_dst_ip      = value[IP_W-1:0];
      REG_NEW_SRC_IP:      cfg.new_src_ip      = value[IP_W-1:0];
      REG_NEW_DST_MAC:     cfg.new_dst_mac     = value[MAC_W-1:0];
      REG_REF_MODE:        cfg.ref_mode        = value[1:0];
      default: ;
    endcase
    apb_access(1'b1, idx, value, rdata);
    apb_access(1'b0, idx, '0, rdata);
    check_field($sformatf("register %s", idx.name()), value, rdata);
  endtask

  task automatic apply_settings(input cfg_t s);
    write_setting(REG_INPUT_UDP_PORT, APB_DATA_W'(s.input_udp_port));
    write_setting(REG_REF_UDP_PORT, APB_DATA_W'(s.ref_udp_port));
    write_setting(REG_INPUT_IP_FILTER, APB_DATA_W'(s.input_ip_filter));
    write_setting(REG_REF_IP_FILTER, APB_DATA_W'(s.ref_ip_filter));
    write_setting(REG_NEW_DST_IP, APB_DATA_W'(s.new_dst_ip));
    write_setting(REG_NEW_SRC_IP, APB_DATA_W'(s.new_src_ip));
    write_setting(REG_NEW_DST_MAC, APB_DATA_W'(s.new_dst_mac));
    write_setting(REG_REF_MODE, APB_DATA_W'(s.ref_mode));
    @(posedge clk);
  endtask

  // random settings, leaning on zero and all-ones
  function automatic cfg_t roll_settings();
    cfg_t s;
    case ($urandom_range(0, 2))
      0:       s.input_udp_port = '0;
      1:       s.input_udp_port = '1;
      default: s.input_udp_port = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       s.ref_udp_port = '0;
      1:       s.ref_udp_port = '1;
      2:       s.ref_udp_port = s.input_udp_port;  // port shared with forwarding
      default: s.ref_udp_port = 16'($urandom);
    endcase
    s.input_ip_filter = $urandom_range(0, 1) ? '0 : $urandom;
    s.ref_ip_filter   = $urandom_range(0, 1) ? '0 : $urandom;
    s.new_dst_ip  = $urandom_range(0, 1) ? '0 : ($urandom_range(0, 3) == 0 ? '1 : $urandom);
    s.new_src_ip  = $urandom_range(0, 1) ? '0 : ($urandom_range(0, 3) == 0 ? '1 : $urandom);
    s.new_dst_mac = $urandom_range(0, 1) ? '0 :
                    ($urandom_range(0, 3) == 0 ? '1 : {16'($urandom), 32'($urandom)});
    s.ref_mode    = 2'($urandom_range(0, 3));
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // header generation
  // ---------------------------------------------------------------------------
  function automatic hdr_t make_header(input hdr_kind_t kind);
    hdr_t h;
    // well-formed header aimed at the forwarding rule
    h.ether_type      = ETH_IPV4;
    h.ip_protocol     = PROTO_UDP;
    h.ip_dst_addr     = (cfg.input_ip_filter != '0) ? cfg.input_ip_filter : $urandom;
    h.ip_src_addr     = $urandom;
    h.udp_dst_port    = cfg.input_udp_port;
    h.ip_total_length = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 19))
                                                    : 16'($urandom);
    h.dst_mac_addr    = {16'($urandom), 32'($urandom)};
    case (kind)
      HDR_REF: begin
        h.udp_dst_port = cfg.ref_udp_port;
        h.ip_dst_addr  = (cfg.ref_ip_filter != '0) ? cfg.ref_ip_filter : $urandom;
      end
      HDR_NEAR: begin
        // one field broken
        case ($urandom_range(0, 3))
          0: h.ether_type = $urandom_range(0, 1) ? ETH_IPV4_SWAPPED : 16'($urandom);
          1: h.ip_protocol = $urandom_range(0, 1) ? PROTO_TCP : 8'($urandom);
          2: h.udp_dst_port = h.udp_dst_port ^ (16'd1 << $urandom_range(0, 15));
          default: h.ip_dst_addr = h.ip_dst_addr ^ (32'd1 << $urandom_range(0, 31));
        endcase
      end
      HDR_NOISE: begin
        h.ether_type   = 16'($urandom);
        h.ip_protocol  = 8'($urandom);
        h.ip_dst_addr  = $urandom;
        h.udp_dst_port = 16'($urandom);
      end
      default: ;
    endcase
    return h;
  endfunction

  function automatic hdr_kind_t pick_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return HDR_FWD;
    if (r < 75) return HDR_REF;
    if (r < 90) return HDR_NEAR;
    return HDR_NOISE;
  endfunction

  task automatic offer(input logic [15:0] eth, input logic [7:0] proto,
                       input logic [31:0] dip, input logic [31:0] sip,
                       input logic [15:0] port, input logic [15:0] tlen,
                       input logic [47:0] mac);
    hdr_t h;
    h.ether_type      = eth;
    h.ip_protocol     = proto;
    h.ip_dst_addr     = dip;
    h.ip_src_addr     = sip;
    h.udp_dst_port    = port;
    h.ip_total_length = tlen;
    h.dst_mac_addr    = mac;
    pending.push_back(h);
  endtask

  // wait until every queued word has gone through and its result has come back
  task automatic drain();
    while (pending.size() != 0 || in_ch.valid || forecast.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_ch.valid           = 1'b0;
    in_ch.ether_type      = '0;
    in_ch.ip_protocol     = '0;
    in_ch.ip_dst_addr     = '0;
    in_ch.ip_src_addr     = '0;
    in_ch.udp_dst_port    = '0;
    in_ch.ip_total_length = '0;
    in_ch.dst_mac_addr    = '0;
    out_ch.ready          = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // separate reference port, no address filters, no rewrites
    apply_settings(cfg_t'{input_udp_port: 16'h1234, ref_udp_port: 16'h4321,
                          input_ip_filter: '0, ref_ip_filter: '0, new_dst_ip: '0,
                          new_src_ip: '0, new_dst_mac: '0, ref_mode: REF_MODE_SEP});
    offer(ETH_IPV4, PROTO_UDP, 32'h0A00_0002, 32'h0A00_0001, 16'h1234, 16'd100,
          48'h0011_2233_4455);
    offer(ETH_IPV4_SWAPPED, PROTO_UDP, 32'h0A00_0002, 32'h0A00_0001, 16'h1234, 16'd100,
          48'h0011_2233_4455);
    offer(ETH_IPV4, PROTO_TCP, 32'h0A00_0002, 32'h0A00_0001, 16'h1234, 16'd100,
          48'h0011_2233_4455);
    offer(ETH_IPV4, PROTO_UDP, 32'h0A00_0002, 32'h0A00_0001, 16'h1235, 16'd100,
          48'h0011_2233_4455);
    // reference port hit, then the same port on a non-udp packet
    offer(ETH_IPV4, PROTO_UDP, 32'h0A00_0003, 32'h0A00_0001, 16'h4321, 16'd64,
          48'h0011_2233_4456);
    offer(ETH_IPV4, PROTO_TCP, 32'h0A00_0003, 32'h0A00_0001, 16'h4321, 16'd64,
          48'h0011_2233_4456);
    // total length around the ip header size, udp length wraps below it
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0101, 32'hC0A8_0102, 16'h1234, 16'd0, '0);
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0101, 32'hC0A8_0102, 16'h1234, 16'd19, '0);
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0101, 32'hC0A8_0102, 16'h1234, 16'd20, '0);
    offer(ETH_IPV4, PROTO_UDP, '1, '1, 16'h1234, '1, '1);
    offer(ETH_IPV4, PROTO_UDP, '0, '0, 16'h1234, 16'd28, '0);
    offer('0, '0, '0, '0, '0, '0, '0);
    offer('1, '1, '1, '1, '1, '1, '1);
    drain();

    // extreme settings: every rewrite on, both address filters, counting forwarded
    apply_settings(cfg_t'{input_udp_port: '1, ref_udp_port: '0,
                          input_ip_filter: 32'hC0A8_0001, ref_ip_filter: 32'h0A00_0001,
                          new_dst_ip: '1, new_src_ip: 32'd1, new_dst_mac: '1,
                          ref_mode: REF_MODE_FWD});
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0001, 32'h0101_0101, '1, 16'd1500, 48'h0200_0000_0001);
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0002, 32'h0101_0101, '1, 16'd1500, 48'h0200_0000_0001);
    offer(ETH_IPV4, PROTO_UDP, 32'h0A00_0001, 32'h0101_0101, '0, 16'd60, 48'h0200_0000_0002);
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0001, '1, '1, 16'd0, '1);
    drain();

    // reference port equal to the forwarding port, counting separately
    write_setting(REG_REF_UDP_PORT, APB_DATA_W'(16'hFFFF));
    write_setting(REG_REF_IP_FILTER, APB_DATA_W'(32'hC0A8_0009));
    write_setting(REG_REF_MODE, APB_DATA_W'(REF_MODE_SEP));
    @(posedge clk);
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0001, 32'h0101_0101, '1, 16'd80, 48'h0200_0000_0003);
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0009, 32'h0101_0101, '1, 16'd80, 48'h0200_0000_0003);
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0008, 32'h0101_0101, '1, 16'd80, 48'h0200_0000_0003);
    drain();

    // counting done elsewhere, and the unused mode value
    write_setting(REG_REF_MODE, APB_DATA_W'(REF_MODE_EXT));
    @(posedge clk);
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0001, 32'h0202_0202, '1, 16'd90, 48'h0200_0000_0004);
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0009, 32'h0202_0202, '1, 16'd90, 48'h0200_0000_0004);
    drain();
    write_setting(REG_REF_MODE, APB_DATA_W'(REF_MODE_RSVD));
    @(posedge clk);
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0001, 32'h0202_0202, '1, 16'd90, 48'h0200_0000_0005);
    offer(ETH_IPV4, PROTO_UDP, 32'hC0A8_0009, 32'h0202_0202, '1, 16'd90, 48'h0200_0000_0005);
    drain();

    // random phases, each under fresh settings; the last one without idling
    for (int phase = 0; phase < 6; phase++) begin
      apply_settings(roll_settings());
      calm = (phase == 5);
      repeat (290) pending.push_back(make_header(pick_kind()));
      if (phase == 1) hold_go = 1'b1;
      drain();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
